FILE: rtl/core/uer_pkg.sv
// Shared constants, codes and widths for the ultrasonic echo ranger.
package uer_pkg;

    // Field and register widths
    localparam int REQ_W      = 2;
    localparam int CAPTURE_W  = 16;
    localparam int DIST_W     = 15;
    localparam int MS_W       = 32;
    localparam int TRIG_MS_W  = 8;
    localparam int TOUT_MS_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    // Event codes carried in req_type
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POLL    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS = 1'd1;

    // Configuration reset values
    localparam logic [TRIG_MS_W-1:0] TRIGGER_MS_RST = 8'd1;
    localparam logic [TOUT_MS_W-1:0] TIMEOUT_MS_RST = 10'd30;

    // Phase codes
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_TRIG   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_WAIT   = 2'd2;
    localparam logic [PHASE_W-1:0] PH_UNUSED = 2'd3;

endpackage

FILE: rtl/core/uer_if.sv
// Valid/ready channel interfaces for ranger events and results.
interface uer_req_if;
    logic                          valid;
    logic                          ready;
    logic [uer_pkg::REQ_W-1:0]     req_type;
    logic [uer_pkg::CAPTURE_W-1:0] capture_time;

    modport source (output valid, output req_type, output capture_time, input ready);
    modport sink   (input valid, input req_type, input capture_time, output ready);
endinterface

interface uer_res_if;
    logic                       valid;
    logic                       ready;
    logic [uer_pkg::DIST_W-1:0] distance_us;
    logic                       distance_valid;
    logic                       trigger_out;
    logic                       measuring;
    logic                       new_ready;

    modport source (output valid, output distance_us, output distance_valid,
                    output trigger_out, output measuring, output new_ready, input ready);
    modport sink   (input valid, input distance_us, input distance_valid,
                    input trigger_out, input measuring, input new_ready, output ready);
endinterface

FILE: rtl/core/ultrasonic_echo_ranger_core.sv
// Ultrasonic ranger core: trigger timing, echo pulse timing and distance reads.
//
//  channel | direction | payload                                              | handshake
//  --------+-----------+------------------------------------------------------+-----------
//  req     | in        | req_type, capture_time                               | valid/ready
//  res     | out       | distance_us, distance_valid, trigger_out, measuring, | valid/ready
//          |           | new_ready                                            |
//  cfg     | in        | cfg_wen, cfg_index, cfg_wdata                        | write only
//
// One event is taken per cycle; its result is in the output register on the next cycle.
// Throughput is set by the single output register: a new event is taken whenever the
// register is empty or its item leaves in the same cycle.
// A stalled result holds req.ready low until res.ready returns.
// Reset: phase idle, rising edge armed, counters zero, trigger_ms 1, timeout_ms 30.
module ultrasonic_echo_ranger_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    uer_req_if.sink                        req,
    uer_res_if.source                      res,
    input  logic                           cfg_wen,
    input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration
    logic [uer_pkg::TRIG_MS_W-1:0] trigger_ms_reg;
    logic [uer_pkg::TOUT_MS_W-1:0] timeout_ms_reg;

    // Ranger state
    logic [uer_pkg::PHASE_W-1:0]   phase_reg,         phase_next;
    logic [uer_pkg::MS_W-1:0]      ms_now_reg,        ms_now_next;
    logic [uer_pkg::MS_W-1:0]      trigger_start_reg, trigger_start_next;
    logic [uer_pkg::MS_W-1:0]      wait_start_reg,    wait_start_next;
    logic [uer_pkg::CAPTURE_W-1:0] echo_rise_reg,     echo_rise_next;
    logic [uer_pkg::CAPTURE_W-1:0] pulse_width_reg,   pulse_width_next;
    logic                          pending_reg,       pending_next;
    logic                          expect_rise_reg,   expect_rise_next;
    logic                          trigger_reg,       trigger_next;

    // Result register
    logic                          res_valid_reg;
    logic [uer_pkg::DIST_W-1:0]    dist_reg,          dist_next;
    logic                          dist_valid_reg,    dist_valid_next;
    logic                          trig_out_reg;
    logic                          measuring_reg;
    logic                          new_ready_reg;

    logic                          in_fire;
    logic [uer_pkg::MS_W-1:0]      trig_elapsed;
    logic [uer_pkg::MS_W-1:0]      wait_elapsed;

    assign req.ready = !res_valid_reg || res.ready;
    assign in_fire   = req.valid && req.ready;

    assign trig_elapsed = ms_now_reg - trigger_start_reg;
    assign wait_elapsed = ms_now_reg - wait_start_reg;

    // Event decode and next state
    always_comb
    begin
        phase_next         = phase_reg;
        ms_now_next        = ms_now_reg;
        trigger_start_next = trigger_start_reg;
        wait_start_next    = wait_start_reg;
        echo_rise_next     = echo_rise_reg;
        pulse_width_next   = pulse_width_reg;
        pending_next       = pending_reg;
        expect_rise_next   = expect_rise_reg;
        trigger_next       = trigger_reg;
        dist_next          = '0;
        dist_valid_next    = 1'b0;
        unique case (req.req_type)
            uer_pkg::REQ_TICK:
            begin
                ms_now_next = ms_now_reg + 32'd1;
            end
            uer_pkg::REQ_POLL:
            begin
                priority if (phase_reg == uer_pkg::PH_TRIG)
                begin
                    if (trig_elapsed >= {24'd0, trigger_ms_reg})
                    begin
                        trigger_next    = 1'b0;
                        phase_next      = uer_pkg::PH_WAIT;
                        wait_start_next = ms_now_reg;
                    end
                end
                else if (phase_reg == uer_pkg::PH_WAIT)
                begin
                    if (wait_elapsed > {22'd0, timeout_ms_reg})
                    begin
                        phase_next       = uer_pkg::PH_IDLE;
                        expect_rise_next = 1'b1;
                    end
                end
                else
                begin
                    // idle, and the unused code, start a new trigger pulse
                    trigger_next       = 1'b1;
                    trigger_start_next = ms_now_reg;
                    phase_next         = uer_pkg::PH_TRIG;
                end
            end
            uer_pkg::REQ_CAPTURE:
            begin
                if (expect_rise_reg)
                begin
                    echo_rise_next   = req.capture_time;
                    phase_next       = uer_pkg::PH_WAIT;
                    wait_start_next  = ms_now_reg;
                    expect_rise_next = 1'b0;
                end
                else
                begin
                    pulse_width_next = req.capture_time - echo_rise_reg;
                    pending_next     = 1'b1;
                    phase_next       = uer_pkg::PH_IDLE;
                    expect_rise_next = 1'b1;
                end
            end
            uer_pkg::REQ_READ:
            begin
                if (pending_reg)
                begin
                    pending_next    = 1'b0;
                    dist_next       = pulse_width_reg[uer_pkg::CAPTURE_W-1:1];
                    dist_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ms_reg <= uer_pkg::TRIGGER_MS_RST;
            timeout_ms_reg <= uer_pkg::TIMEOUT_MS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                uer_pkg::CFG_TRIGGER_MS: trigger_ms_reg <= cfg_wdata[uer_pkg::TRIG_MS_W-1:0];
                uer_pkg::CFG_TIMEOUT_MS: timeout_ms_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // State update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= uer_pkg::PH_IDLE;
            ms_now_reg        <= '0;
            trigger_start_reg <= '0;
            wait_start_reg    <= '0;
            echo_rise_reg     <= '0;
            pulse_width_reg   <= '0;
            pending_reg       <= 1'b0;
            expect_rise_reg   <= 1'b1;
            trigger_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            ms_now_reg        <= ms_now_next;
            trigger_start_reg <= trigger_start_next;
            wait_start_reg    <= wait_start_next;
            echo_rise_reg     <= echo_rise_next;
            pulse_width_reg   <= pulse_width_next;
            pending_reg       <= pending_next;
            expect_rise_reg   <= expect_rise_next;
            trigger_reg       <= trigger_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Output payload, reflects state after the event
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dist_reg       <= dist_next;
            dist_valid_reg <= dist_valid_next;
            trig_out_reg   <= trigger_next;
            measuring_reg  <= (phase_next == uer_pkg::PH_WAIT);
            new_ready_reg  <= pending_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.distance_us    = dist_reg;
    assign res.distance_valid = dist_valid_reg;
    assign res.trigger_out    = trig_out_reg;
    assign res.measuring      = measuring_reg;
    assign res.new_ready      = new_ready_reg;

    // A read with a pending measurement returns it and clears the flag
    a_read_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.req_type == uer_pkg::REQ_READ && pending_reg)
        |=> (res_valid_reg && dist_valid_reg && !new_ready_reg))
        else $error("pending read did not return a valid distance");

    // Only reads ever report a distance
    a_nonread_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.req_type != uer_pkg::REQ_READ) |=> !dist_valid_reg)
        else $error("non-read item reported a distance");

    // Tick advances the millisecond counter by exactly one
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req.req_type == uer_pkg::REQ_TICK)
        |=> (ms_now_reg == $past(ms_now_reg) + 32'd1))
        else $error("millisecond counter did not advance on tick");

    // Counter holds when no tick is taken
    a_ms_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_fire && req.req_type == uer_pkg::REQ_TICK) |=> $stable(ms_now_reg))
        else $error("millisecond counter moved without a tick");

    // The unused phase code is never entered
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != uer_pkg::PH_UNUSED)
        else $error("phase reached unused code");

endmodule

FILE: verif/ultrasonic_echo_ranger_core_test.sv
// Self-checking testbench for the ultrasonic echo ranger core.
module ultrasonic_echo_ranger_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1550;
    localparam int PHASE_ITEMS  = 70;

    // One result item as seen on the result channel
    typedef struct packed {
        logic [uer_pkg::DIST_W-1:0] dist_us;
        logic                       dvalid;
        logic                       trig;
        logic                       meas;
        logic                       newr;
    } ranging_result_t;

    // Ranger behavior and the queue of results it predicts
    class range_scoreboard;
        bit [uer_pkg::TRIG_MS_W-1:0]  trig_ms;
        bit [uer_pkg::TOUT_MS_W-1:0]  tout_ms;
        logic [uer_pkg::PHASE_W-1:0]  phase;
        bit [uer_pkg::MS_W-1:0]       ms_now;
        bit [uer_pkg::MS_W-1:0]       trig_start;
        bit [uer_pkg::MS_W-1:0]       wait_start;
        bit [uer_pkg::CAPTURE_W-1:0]  echo_rise;
        bit [uer_pkg::CAPTURE_W-1:0]  width;
        bit                           pending;
        bit                           arm_rise;
        bit                           trig_level;
        ranging_result_t              want_q[$];
        int                           errors;
        int                           checked;

        function new();
            trig_ms    = uer_pkg::TRIGGER_MS_RST;
            tout_ms    = uer_pkg::TIMEOUT_MS_RST;
            phase      = uer_pkg::PH_IDLE;
            ms_now     = '0;
            trig_start = '0;
            wait_start = '0;
            echo_rise  = '0;
            width      = '0;
            pending    = 1'b0;
            arm_rise   = 1'b1;
            trig_level = 1'b0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void set_reg(logic [uer_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
            if (idx == uer_pkg::CFG_TRIGGER_MS)
                trig_ms = val[uer_pkg::TRIG_MS_W-1:0];
            else
                tout_ms = val[uer_pkg::TOUT_MS_W-1:0];
        endfunction

        function int outstanding();
            return want_q.size();
        endfunction

        // Poll: arm trigger, drop it after trig_ms, or give up after tout_ms
        function void poll();
            bit [uer_pkg::MS_W-1:0] elapsed;
            if (phase == uer_pkg::PH_TRIG)
            begin
                elapsed = ms_now - trig_start;
                if (elapsed >= {{(uer_pkg::MS_W-uer_pkg::TRIG_MS_W){1'b0}}, trig_ms})
                begin
                    trig_level = 1'b0;
                    phase      = uer_pkg::PH_WAIT;
                    wait_start = ms_now;
                end
            end
            else if (phase == uer_pkg::PH_WAIT)
            begin
                elapsed = ms_now - wait_start;
                if (elapsed > {{(uer_pkg::MS_W-uer_pkg::TOUT_MS_W){1'b0}}, tout_ms})
                begin
                    phase    = uer_pkg::PH_IDLE;
                    arm_rise = 1'b1;
                end
            end
            else
            begin
                trig_level = 1'b1;
                trig_start = ms_now;
                phase      = uer_pkg::PH_TRIG;
            end
        endfunction

        // Echo edges alternate rising / falling
        function void capture(bit [uer_pkg::CAPTURE_W-1:0] t);
            if (arm_rise)
            begin
                echo_rise  = t;
                phase      = uer_pkg::PH_WAIT;
                wait_start = ms_now;
                arm_rise   = 1'b0;
            end
            else
            begin
                width    = t - echo_rise;
                pending  = 1'b1;
                phase    = uer_pkg::PH_IDLE;
                arm_rise = 1'b1;
            end
        endfunction

        function void note_event(logic [uer_pkg::REQ_W-1:0] kind,
                                 logic [uer_pkg::CAPTURE_W-1:0] t);
            ranging_result_t r;
            r = '0;
            unique case (kind)
                uer_pkg::REQ_TICK:    ms_now = ms_now + 32'd1;
                uer_pkg::REQ_POLL:    poll();
                uer_pkg::REQ_CAPTURE: capture(t);
                default:
                begin
                    // distance read
                    if (pending)
                    begin
                        pending   = 1'b0;
                        r.dist_us = width[uer_pkg::CAPTURE_W-1:1];
                        r.dvalid  = 1'b1;
                    end
                end
            endcase
            r.trig = trig_level;
            r.meas = (phase == uer_pkg::PH_WAIT);
            r.newr = pending;
            want_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR: result %0d: %s", checked, msg);
        endtask

        task check_result(ranging_result_t got);
            ranging_result_t want;
            checked++;
            if (want_q.size() == 0)
            begin
                report("result arrived with nothing expected");
                return;
            end
            want = want_q.pop_front();
            if (got.dist_us !== want.dist_us)
                report($sformatf("distance_us %0d, expected %0d", got.dist_us, want.dist_us));
            if (got.dvalid !== want.dvalid)
                report($sformatf("distance_valid %b, expected %b", got.dvalid, want.dvalid));
            if (got.trig !== want.trig)
                report($sformatf("trigger_out %b, expected %b", got.trig, want.trig));
            if (got.meas !== want.meas)
                report($sformatf("measuring %b, expected %b", got.meas, want.meas));
            if (got.newr !== want.newr)
                report($sformatf("new_ready %b, expected %b", got.newr, want.newr));
        endtask

        task close();
            while (want_q.size() != 0)
            begin
                void'(want_q.pop_front());
                report("expected result never arrived");
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wen;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_wdata;

    uer_req_if req_ch ();
    uer_res_if res_ch ();

    range_scoreboard sb;
    bit calm;
    int sent;

    ultrasonic_echo_ranger_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Random capture time and random event code
    function automatic logic [uer_pkg::CAPTURE_W-1:0] rand_time();
        bit [31:0] r;
        r = $urandom();
        return r[uer_pkg::CAPTURE_W-1:0];
    endfunction

    function automatic logic [uer_pkg::REQ_W-1:0] rand_kind();
        bit [31:0] r;
        r = $urandom();
        return r[uer_pkg::REQ_W-1:0];
    endfunction

    // Offer one item, wait for acceptance, then maybe go idle
    task automatic send_event(input logic [uer_pkg::REQ_W-1:0] kind,
                              input logic [uer_pkg::CAPTURE_W-1:0] t);
        int gap;
        @(negedge clk);
        req_ch.valid        = 1'b1;
        req_ch.req_type     = kind;
        req_ch.capture_time = t;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_event(kind, t);
        sent++;
        gap = gap_len();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering and wait for every expected result
    task automatic settle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[uer_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_wen = 1'b0;
    endtask

    task automatic noise_burst(input int n);
        repeat (n) send_event(rand_kind(), rand_time());
    endtask

    // Trigger, hold, then either an echo pulse and usually a read, or a wait for the timeout
    task automatic measure_once(input bit want_timeout);
        int thr;
        int n;
        send_event(uer_pkg::REQ_POLL, rand_time());
        thr = sb.trig_ms;
        n = thr + $urandom_range(0, 2) - 1;
        for (int i = 1; i <= n; i++)
        begin
            send_event(uer_pkg::REQ_TICK, rand_time());
            if (i >= thr - 1 || $urandom_range(0, 9) == 0)
                send_event(uer_pkg::REQ_POLL, rand_time());
        end
        send_event(uer_pkg::REQ_POLL, rand_time());
        if (want_timeout || (sb.tout_ms <= 64 && $urandom_range(0, 9) < 3))
        begin
            thr = sb.tout_ms;
            n = want_timeout ? thr + 1 : thr + $urandom_range(0, 1);
            for (int i = 1; i <= n; i++)
            begin
                send_event(uer_pkg::REQ_TICK, rand_time());
                if (i >= thr || $urandom_range(0, 9) == 0)
                    send_event(uer_pkg::REQ_POLL, rand_time());
            end
            send_event(uer_pkg::REQ_POLL, rand_time());
        end
        else
        begin
            send_event(uer_pkg::REQ_CAPTURE, rand_time());
            repeat ($urandom_range(0, 2))
            begin
                n = $urandom_range(0, 2);
                send_event(n == 2 ? uer_pkg::REQ_READ :
                           (n == 1 ? uer_pkg::REQ_POLL : uer_pkg::REQ_TICK),
                           rand_time());
            end
            send_event(uer_pkg::REQ_CAPTURE, rand_time());
            if ($urandom_range(0, 4) != 0)
                send_event(uer_pkg::REQ_READ, rand_time());
        end
    endtask

    // Result side: random ready, a few long hold-offs, check each item
    initial
    begin : result_sink
        int idle_left;
        int hold_left;
        int next_hold;
        ranging_result_t got;
        res_ch.ready = 1'b0;
        idle_left = 0;
        hold_left = 0;
        next_hold = 200;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (next_hold <= 1200 && sb.checked >= next_hold)
            begin
                hold_left = 60;
                next_hold += 500;
            end
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else if (idle_left > 0)
            begin
                res_ch.ready = 1'b0;
                idle_left--;
            end
            else
            begin
                res_ch.ready = 1'b1;
                idle_left = gap_len();
            end
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
            begin
                got.dist_us = res_ch.distance_us;
                got.dvalid  = res_ch.distance_valid;
                got.trig    = res_ch.trigger_out;
                got.meas    = res_ch.measuring;
                got.newr    = res_ch.new_ready;
                sb.check_result(got);
            end
        end
    end

    // Main stimulus
    initial
    begin : stimulus
        int target;
        int phase_no;
        int phase_end;
        sb = new();
        calm = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = uer_pkg::REQ_TICK;
        req_ch.capture_time = '0;
        cfg_wen = 1'b0;
        cfg_index = uer_pkg::CFG_TRIGGER_MS;
        cfg_wdata = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset config, read with nothing pending, capture while trigger
        // is high, widest pulse, wrapped pulse, zero-width pulse, early poll
        send_event(uer_pkg::REQ_READ, 16'h0000);
        send_event(uer_pkg::REQ_POLL, 16'hFFFF);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_CAPTURE, 16'h0000);
        send_event(uer_pkg::REQ_CAPTURE, 16'hFFFF);
        send_event(uer_pkg::REQ_READ, 16'h0000);
        send_event(uer_pkg::REQ_READ, 16'hFFFF);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_TICK, 16'hFFFF);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_CAPTURE, 16'hFFF0);
        send_event(uer_pkg::REQ_CAPTURE, 16'h0010);
        send_event(uer_pkg::REQ_READ, 16'h0000);
        send_event(uer_pkg::REQ_CAPTURE, 16'h5555);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_CAPTURE, 16'hAAAA);
        send_event(uer_pkg::REQ_CAPTURE, 16'h1234);
        send_event(uer_pkg::REQ_CAPTURE, 16'h1234);
        send_event(uer_pkg::REQ_READ, 16'h0000);
        send_event(uer_pkg::REQ_READ, 16'h0000);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_TICK, 16'h0000);
        send_event(uer_pkg::REQ_POLL, 16'h0000);
        send_event(uer_pkg::REQ_POLL, 16'h0000);

        // Random phases, each under a fresh configuration
        target = RANDOM_ITEMS;
        phase_no = 0;
        while (sent < target)
        begin
            phase_no++;
            settle();
            case (phase_no)
                1:
                begin
                    write_reg(uer_pkg::CFG_TRIGGER_MS, 0);
                    write_reg(uer_pkg::CFG_TIMEOUT_MS, 0);
                end
                3:
                begin
                    write_reg(uer_pkg::CFG_TIMEOUT_MS, 1023);
                    write_reg(uer_pkg::CFG_TRIGGER_MS, 255);
                end
                5:
                begin
                    write_reg(uer_pkg::CFG_TRIGGER_MS, $urandom_range(0, 255));
                    write_reg(uer_pkg::CFG_TIMEOUT_MS, $urandom_range(0, 1023));
                end
                default:
                begin
                    if (phase_no % 4 == 2)
                    begin
                        write_reg(uer_pkg::CFG_TRIGGER_MS, $urandom_range(0, 40));
                        write_reg(uer_pkg::CFG_TIMEOUT_MS, $urandom_range(0, 60));
                    end
                    else
                    begin
                        write_reg(uer_pkg::CFG_TRIGGER_MS, $urandom_range(0, 5));
                        write_reg(uer_pkg::CFG_TIMEOUT_MS, $urandom_range(0, 8));
                    end
                end
            endcase
            if (phase_no == 3)
            begin
                // longest hold and longest timeout, walked tick by tick
                calm = 1'b0;
                measure_once(1'b1);
            end
            else
            begin
                phase_end = sent + PHASE_ITEMS;
                while (sent < phase_end && sent < target)
                begin
                    calm = ($urandom_range(0, 4) == 0);
                    if (phase_no == 5 || $urandom_range(0, 4) == 0)
                        noise_burst($urandom_range(3, 12));
                    else
                        measure_once(1'b0);
                end
            end
        end
        calm = 1'b0;

        settle();
        repeat (8) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(10_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
